/* hdl/thp_pkg.sv */
// shared types and constants for the tracker module header parser
package thp_pkg;

    localparam int OFF_W         = 33;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [OFF_W-1:0] OFF_MAX       = {OFF_W{1'b1}};
    localparam logic [OFF_W-1:0] MAGIC_LEN     = 33'd17;
    localparam logic [OFF_W-1:0] XM_TITLE_LO   = 33'd17;
    localparam logic [OFF_W-1:0] XM_TITLE_HI   = 33'd36;
    localparam logic [OFF_W-1:0] MOD_TITLE_LEN = 33'd20;
    localparam logic [OFF_W-1:0] OFF_EOF_MARK  = 33'd37;
    localparam logic [OFF_W-1:0] OFF_VERSION   = 33'd58;
    localparam logic [OFF_W-1:0] OFF_HDR_LEN   = 33'd60;
    localparam logic [OFF_W-1:0] OFF_SONG_LEN  = 33'd64;
    localparam logic [OFF_W-1:0] OFF_CHANNELS  = 33'd68;
    localparam logic [OFF_W-1:0] OFF_PATTERNS  = 33'd70;
    localparam logic [OFF_W-1:0] OFF_INSTR     = 33'd72;
    localparam logic [OFF_W-1:0] OFF_ORD_CNT   = 33'd950;
    localparam logic [OFF_W-1:0] OFF_ORD_TAB   = 33'd952;
    localparam logic [OFF_W-1:0] OFF_SIG       = 33'd1080;
    // size limits expressed as last-byte offset (size minus one)
    localparam logic [OFF_W-1:0] XM_MIN_LAST   = 33'd79;
    localparam logic [OFF_W-1:0] MOD_MIN_LAST  = 33'd1083;
    localparam logic [OFF_W-1:0] HDR_BASE_LAST = 33'd59;

    localparam logic [7:0]  EOF_MARK       = 8'h1A;
    localparam logic [31:0] HDR_LEN_MIN    = 32'd20;
    localparam logic [7:0]  ORD_TAB_LEN    = 8'd128;
    localparam logic [15:0] MOD_INSTR      = 16'd31;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNSUP   = 2'd1,
        ST_TRUNC   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FMT_NONE = 2'd0,
        FMT_XM   = 2'd1,
        FMT_MOD  = 2'd2
    } format_t;

    // header summary handed from the capture front to the decision back
    typedef struct packed {
        logic [OFF_W-1:0] last_off;
        logic             xm_match;
        logic             eof_ok;
        logic [31:0]      hdr_len;
        logic [15:0]      version;
        logic [15:0]      xm_song_len;
        logic [15:0]      xm_channels;
        logic [15:0]      xm_patterns;
        logic [15:0]      xm_instr;
        logic [4:0]       xm_title_end;
        logic [4:0]       mod_title_end;
        logic [31:0]      mod_sig;
        logic [7:0]       mod_ord_cnt;
        logic [7:0]       ord_max;
    } hdr_rec_t;

endpackage

/* hdl/thp_front.sv */
// capture front: counts bytes and captures header fields at fixed offsets
module thp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             q_full,
    output logic             push,
    output thp_pkg::hdr_rec_t rec
);
    import thp_pkg::*;

    logic [OFF_W-1:0] off_reg, off_next;
    logic             match_reg, match_next;
    logic             eof_reg, eof_next;
    logic [31:0]      hdr_len_reg, hdr_len_next;
    logic [15:0]      version_reg, version_next;
    logic [15:0]      song_reg, song_next;
    logic [15:0]      chan_reg, chan_next;
    logic [15:0]      pat_reg, pat_next;
    logic [15:0]      instr_reg, instr_next;
    logic [4:0]       xm_title_reg, xm_title_next;
    logic [4:0]       mod_title_reg, mod_title_next;
    logic [31:0]      sig_reg, sig_next;
    logic [7:0]       ord_cnt_reg, ord_cnt_next;
    logic [7:0]       ord_max_reg, ord_max_next;

    hdr_rec_t cap;
    logic     accept;
    logic     blank;
    logic [7:0] ord_len;
    logic [6:0] ord_idx;

    function automatic logic [7:0] magic_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "E";
            5'd1:    c = "x";
            5'd2:    c = "t";
            5'd3:    c = "e";
            5'd4:    c = "n";
            5'd5:    c = "d";
            5'd6:    c = "e";
            5'd7:    c = "d";
            5'd8:    c = " ";
            5'd9:    c = "M";
            5'd10:   c = "o";
            5'd11:   c = "d";
            5'd12:   c = "u";
            5'd13:   c = "l";
            5'd14:   c = "e";
            5'd15:   c = ":";
            5'd16:   c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && last_byte;
    assign rec      = cap;

    always_comb
    begin
        blank   = (data_byte == 8'h00) || (data_byte == 8'h20);
        ord_len = ((ord_cnt_reg == 8'd0) || (ord_cnt_reg > ORD_TAB_LEN)) ? ORD_TAB_LEN
                                                                          : ord_cnt_reg;
        ord_idx = 7'(off_reg - OFF_ORD_TAB);

        cap.last_off      = off_reg;
        cap.xm_match      = match_reg;
        cap.eof_ok        = eof_reg;
        cap.hdr_len       = hdr_len_reg;
        cap.version       = version_reg;
        cap.xm_song_len   = song_reg;
        cap.xm_channels   = chan_reg;
        cap.xm_patterns   = pat_reg;
        cap.xm_instr      = instr_reg;
        cap.xm_title_end  = xm_title_reg;
        cap.mod_title_end = mod_title_reg;
        cap.mod_sig       = sig_reg;
        cap.mod_ord_cnt   = ord_cnt_reg;
        cap.ord_max       = ord_max_reg;

        if ((off_reg < MAGIC_LEN) && (data_byte != magic_char(off_reg[4:0])))
            cap.xm_match = 1'b0;
        if ((off_reg >= XM_TITLE_LO) && (off_reg <= XM_TITLE_HI) && !blank)
            cap.xm_title_end = 5'(off_reg[5:0] - 6'd16);
        if ((off_reg < MOD_TITLE_LEN) && !blank)
            cap.mod_title_end = 5'(off_reg[4:0] + 5'd1);
        if (off_reg == OFF_EOF_MARK)
            cap.eof_ok = (data_byte == EOF_MARK);
        if (off_reg == OFF_VERSION)          cap.version[7:0]      = data_byte;
        if (off_reg == OFF_VERSION + 33'd1)  cap.version[15:8]     = data_byte;
        if (off_reg == OFF_HDR_LEN)          cap.hdr_len[7:0]      = data_byte;
        if (off_reg == OFF_HDR_LEN + 33'd1)  cap.hdr_len[15:8]     = data_byte;
        if (off_reg == OFF_HDR_LEN + 33'd2)  cap.hdr_len[23:16]    = data_byte;
        if (off_reg == OFF_HDR_LEN + 33'd3)  cap.hdr_len[31:24]    = data_byte;
        if (off_reg == OFF_SONG_LEN)         cap.xm_song_len[7:0]  = data_byte;
        if (off_reg == OFF_SONG_LEN + 33'd1) cap.xm_song_len[15:8] = data_byte;
        if (off_reg == OFF_CHANNELS)         cap.xm_channels[7:0]  = data_byte;
        if (off_reg == OFF_CHANNELS + 33'd1) cap.xm_channels[15:8] = data_byte;
        if (off_reg == OFF_PATTERNS)         cap.xm_patterns[7:0]  = data_byte;
        if (off_reg == OFF_PATTERNS + 33'd1) cap.xm_patterns[15:8] = data_byte;
        if (off_reg == OFF_INSTR)            cap.xm_instr[7:0]     = data_byte;
        if (off_reg == OFF_INSTR + 33'd1)    cap.xm_instr[15:8]    = data_byte;
        if (off_reg == OFF_ORD_CNT)
            cap.mod_ord_cnt = data_byte;
        // only the order entries the song uses count toward the maximum
        if ((off_reg >= OFF_ORD_TAB) && (off_reg < OFF_SIG) &&
            ({1'b0, ord_idx} < ord_len) && (data_byte > ord_max_reg))
            cap.ord_max = data_byte;
        if (off_reg == OFF_SIG)              cap.mod_sig[7:0]      = data_byte;
        if (off_reg == OFF_SIG + 33'd1)      cap.mod_sig[15:8]     = data_byte;
        if (off_reg == OFF_SIG + 33'd2)      cap.mod_sig[23:16]    = data_byte;
        if (off_reg == OFF_SIG + 33'd3)      cap.mod_sig[31:24]    = data_byte;

        off_next       = off_reg;
        match_next     = match_reg;
        eof_next       = eof_reg;
        hdr_len_next   = hdr_len_reg;
        version_next   = version_reg;
        song_next      = song_reg;
        chan_next      = chan_reg;
        pat_next       = pat_reg;
        instr_next     = instr_reg;
        xm_title_next  = xm_title_reg;
        mod_title_next = mod_title_reg;
        sig_next       = sig_reg;
        ord_cnt_next   = ord_cnt_reg;
        ord_max_next   = ord_max_reg;

        if (accept)
        begin
            if (last_byte)
            begin
                // start over for the next file
                off_next       = '0;
                match_next     = 1'b1;
                eof_next       = 1'b0;
                hdr_len_next   = '0;
                version_next   = '0;
                song_next      = '0;
                chan_next      = '0;
                pat_next       = '0;
                instr_next     = '0;
                xm_title_next  = '0;
                mod_title_next = '0;
                sig_next       = '0;
                ord_cnt_next   = '0;
                ord_max_next   = '0;
            end
            else
            begin
                off_next       = (off_reg == OFF_MAX) ? off_reg : off_reg + 33'd1;
                match_next     = cap.xm_match;
                eof_next       = cap.eof_ok;
                hdr_len_next   = cap.hdr_len;
                version_next   = cap.version;
                song_next      = cap.xm_song_len;
                chan_next      = cap.xm_channels;
                pat_next       = cap.xm_patterns;
                instr_next     = cap.xm_instr;
                xm_title_next  = cap.xm_title_end;
                mod_title_next = cap.mod_title_end;
                sig_next       = cap.mod_sig;
                ord_cnt_next   = cap.mod_ord_cnt;
                ord_max_next   = cap.ord_max;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg       <= '0;
            match_reg     <= 1'b1;
            eof_reg       <= 1'b0;
            hdr_len_reg   <= '0;
            version_reg   <= '0;
            song_reg      <= '0;
            chan_reg      <= '0;
            pat_reg       <= '0;
            instr_reg     <= '0;
            xm_title_reg  <= '0;
            mod_title_reg <= '0;
            sig_reg       <= '0;
            ord_cnt_reg   <= '0;
            ord_max_reg   <= '0;
        end
        else
        begin
            off_reg       <= off_next;
            match_reg     <= match_next;
            eof_reg       <= eof_next;
            hdr_len_reg   <= hdr_len_next;
            version_reg   <= version_next;
            song_reg      <= song_next;
            chan_reg      <= chan_next;
            pat_reg       <= pat_next;
            instr_reg     <= instr_next;
            xm_title_reg  <= xm_title_next;
            mod_title_reg <= mod_title_next;
            sig_reg       <= sig_next;
            ord_cnt_reg   <= ord_cnt_next;
            ord_max_reg   <= ord_max_next;
        end
    end

endmodule

/* hdl/thp_queue.sv */
// short queue of header summaries between the capture front and the decision back
module thp_queue #(
    parameter int DEPTH = thp_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  thp_pkg::hdr_rec_t push_rec,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output thp_pkg::hdr_rec_t head_rec
);
    import thp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hdr_rec_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_rec  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("summary pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("summary popped from an empty queue");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue fill count out of step with pushes");

endmodule

/* hdl/thp_back.sv */
// decision back: classifies a header summary and holds the result beat
module thp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  thp_pkg::hdr_rec_t head_rec,
    output logic              pop,
    output logic [1:0]        status,
    output logic [1:0]        format_kind,
    output logic [7:0]        ver_high,
    output logic [7:0]        ver_low,
    output logic [15:0]       order_len,
    output logic [15:0]       channels,
    output logic [15:0]       patterns,
    output logic [15:0]       instruments,
    output logic [4:0]        title_length,
    output logic              out_valid,
    input  logic              out_ready
);
    import thp_pkg::*;

    typedef struct packed {
        status_t     st;
        format_t     fmt;
        logic [7:0]  ver_major;
        logic [7:0]  ver_minor;
        logic [15:0] song_len;
        logic [15:0] chans;
        logic [15:0] pats;
        logic [15:0] instr;
        logic [4:0]  title_len;
    } res_t;

    res_t             res, res_reg;
    logic             valid_reg, valid_next;
    logic [OFF_W-1:0] xm_need;
    logic [7:0]       s0, s1, s2, s3;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_print(input logic [7:0] c);
        return (c >= 8'd32) && (c <= 8'd126);
    endfunction

    function automatic logic sig_is(input logic [31:0] sig, input logic [31:0] txt);
        // txt is written first character high, signature holds first byte low
        return (sig[7:0] == txt[31:24]) && (sig[15:8] == txt[23:16]) &&
               (sig[23:16] == txt[15:8]) && (sig[31:24] == txt[7:0]);
    endfunction

    function automatic logic [15:0] decode_chans(input logic [31:0] sig);
        logic [7:0]  c0, c1, c2, c3;
        logic [15:0] n;
        c0 = sig[7:0];
        c1 = sig[15:8];
        c2 = sig[23:16];
        c3 = sig[31:24];
        n  = 16'd0;
        if (sig_is(sig, "M.K.") || sig_is(sig, "M!K!") ||
            sig_is(sig, "FLT4") || sig_is(sig, "4CHN"))
            n = 16'd4;
        else if (sig_is(sig, "FLT8") || sig_is(sig, "8CHN") ||
                 sig_is(sig, "OKTA") || sig_is(sig, "CD81"))
            n = 16'd8;
        else if (is_dec(c0) && is_dec(c1) && (c2 == "C") && ((c3 == "H") || (c3 == "N")))
            n = 16'(c0[3:0]) * 16'd10 + 16'(c1[3:0]);
        else if (is_dec(c0) && (c1 == "C") && ((c2 == "H") || (c2 == "N")))
            n = 16'(c0[3:0]);
        return n;
    endfunction

    assign s0 = head_rec.mod_sig[7:0];
    assign s1 = head_rec.mod_sig[15:8];
    assign s2 = head_rec.mod_sig[23:16];
    assign s3 = head_rec.mod_sig[31:24];

    // header must end within the file: last offset at least 59 plus header length
    assign xm_need = {1'b0, head_rec.hdr_len} + HDR_BASE_LAST;

    assign pop = q_not_empty && (!valid_reg || out_ready);

    always_comb
    begin
        res     = '0;
        res.st  = ST_OK;
        res.fmt = FMT_NONE;
        if (head_rec.last_off < XM_MIN_LAST)
            res.st = ST_TRUNC;
        else if (head_rec.xm_match)
        begin
            if (!head_rec.eof_ok || (head_rec.hdr_len < HDR_LEN_MIN))
                res.st = ST_INVALID;
            else if (head_rec.last_off < xm_need)
                res.st = ST_TRUNC;
            else
            begin
                res.fmt       = FMT_XM;
                res.ver_major = head_rec.version[15:8];
                res.ver_minor = head_rec.version[7:0];
                res.song_len  = head_rec.xm_song_len;
                res.chans     = head_rec.xm_channels;
                res.pats      = head_rec.xm_patterns;
                res.instr     = head_rec.xm_instr;
                res.title_len = head_rec.xm_title_end;
            end
        end
        else if (head_rec.last_off < MOD_MIN_LAST)
            res.st = ST_TRUNC;
        else if (!(is_print(s0) && is_print(s1) && is_print(s2) && is_print(s3)))
            res.st = ST_UNSUP;
        else
        begin
            res.fmt       = FMT_MOD;
            res.song_len  = {8'd0, head_rec.mod_ord_cnt};
            res.chans     = decode_chans(head_rec.mod_sig);
            res.pats      = {8'd0, head_rec.ord_max} + 16'd1;
            res.instr     = MOD_INSTR;
            res.title_len = head_rec.mod_title_end;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            res_reg <= res;
    end

    assign out_valid    = valid_reg;
    assign status       = res_reg.st;
    assign format_kind  = res_reg.fmt;
    assign ver_high     = res_reg.ver_major;
    assign ver_low      = res_reg.ver_minor;
    assign order_len    = res_reg.song_len;
    assign channels     = res_reg.chans;
    assign patterns     = res_reg.pats;
    assign instruments  = res_reg.instr;
    assign title_length = res_reg.title_len;

    a_fail_no_format: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (res_reg.st != ST_OK)) |-> (res_reg.fmt == FMT_NONE))
        else $error("failed result carries a format");

    a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (res_reg.st != ST_OK)) |->
        ((res_reg.song_len == '0) && (res_reg.chans == '0) && (res_reg.pats == '0) &&
         (res_reg.instr == '0) && (res_reg.title_len == '0)))
        else $error("failed result carries nonzero fields");

    a_mod_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (res_reg.fmt == FMT_MOD)) |->
        ((res_reg.instr == MOD_INSTR) && (res_reg.ver_major == '0) && (res_reg.pats != '0)))
        else $error("mod result with bad fixed fields");

endmodule

/* hdl/tracker_module_header_parser.sv */
// top level: tracker module header parser, capture front, summary queue, decision back
// throughput: one data byte accepted every cycle while the summary queue has room
// out_valid rises once a file's summary has passed the queue and the output register
// the back empties the queue one summary per cycle whenever the output register frees up
// a stalled result holds in the output register; the next file enters until the queue fills
// reset: rst_n async active low clears the byte counter, captured fields, queue and out_valid
module tracker_module_header_parser #(
    parameter int QUEUE_DEPTH = thp_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [1:0]  status,
    output logic [1:0]  format_kind,
    output logic [7:0]  ver_high,
    output logic [7:0]  ver_low,
    output logic [15:0] order_len,
    output logic [15:0] channels,
    output logic [15:0] patterns,
    output logic [15:0] instruments,
    output logic [4:0]  title_length,
    output logic        out_valid,
    input  logic        out_ready
);
    import thp_pkg::*;

    // summary of one file, captured as its last beat is taken
    hdr_rec_t push_rec;
    hdr_rec_t head_rec;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_not_empty;

    // front: byte counter and field capture, stalls only on a full queue
    thp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .q_full    (q_full),
        .push      (push),
        .rec       (push_rec)
    );

    // queue decouples the byte stream from result back pressure
    thp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_rec  (head_rec)
    );

    // back: xm then mod classification into the output register
    thp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .head_rec     (head_rec),
        .pop          (pop),
        .status       (status),
        .format_kind  (format_kind),
        .ver_high     (ver_high),
        .ver_low      (ver_low),
        .order_len    (order_len),
        .channels     (channels),
        .patterns     (patterns),
        .instruments  (instruments),
        .title_length (title_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

endmodule
